// ----- sv/enacc_pkg.sv -----
// enacc_pkg: shared types and constants for the error norm accumulator.
// No dependencies.
`timescale 1ns / 1ps
package enacc_pkg;

   localparam int MAX_CELLS_DEF   = 4096;
   localparam int SAMPLE_BITS_DEF = 24;
   localparam int CELL_BITS       = 13;
   localparam int SQ_BITS         = 62;
   localparam int ROOT_BITS       = 31;
   localparam int NUM_BITS        = 38;
   localparam int Q_SHIFT         = 16;
   localparam int Q_BITS          = 32;
   localparam logic [1:0] ONE_COMPONENT = 2'd1;
   localparam logic [1:0] COUNT_RESET   = 2'd2;

   typedef struct packed {
      logic signed [23:0] test_x;
      logic signed [23:0] ref_x;
      logic signed [23:0] test_y;
      logic signed [23:0] ref_y;
      logic               last_cell;
   } req_type;

   typedef struct packed {
      logic [36:0] abs_l1;
      logic [30:0] abs_l2;
      logic [23:0] abs_linf;
      logic [36:0] ref_l1;
      logic [29:0] ref_l2;
      logic [23:0] ref_linf;
      logic [31:0] rel_l1;
      logic [31:0] rel_l2;
      logic [31:0] rel_linf;
      logic [2:0]  zero_ref_mask;
      logic [12:0] cell_total;
   } rsp_type;

endpackage

// ----- sv/enacc_isqrt.sv -----
// enacc_isqrt: iterative floor square root, two radicand bits per cycle.
// Uses enacc_pkg.
`timescale 1ns / 1ps
module enacc_isqrt (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [enacc_pkg::SQ_BITS-1:0]     value,
   output logic                              done,
   output logic [enacc_pkg::ROOT_BITS-1:0]   root
);
   localparam int RB = enacc_pkg::ROOT_BITS;
   localparam int SB = enacc_pkg::SQ_BITS;

   logic [RB+1:0]   rem_ff, rem_in;
   logic [RB-1:0]   root_ff, root_in;
   logic [SB-1:0]   val_ff, val_in;
   logic [4:0]      cnt_ff, cnt_in;
   logic            busy_ff, busy_in, done_ff, done_in;
   logic [RB+3:0]   rem_sh, trial;

   always_comb begin
      rem_sh  = {rem_ff, val_ff[SB-1:SB-2]};
      trial   = {2'b00, root_ff, 2'b01};
      rem_in  = rem_ff;
      root_in = root_ff;
      val_in  = val_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         root_in = '0;
         val_in  = value;
         cnt_in  = 5'(RB - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         val_in = {val_ff[SB-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = (RB+2)'(rem_sh - trial);
            root_in = {root_ff[RB-2:0], 1'b1};
         end else begin
            rem_in  = (RB+2)'(rem_sh);
            root_in = {root_ff[RB-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff  <= rem_in;
      root_ff <= root_in;
      val_ff  <= val_in;
      cnt_ff  <= cnt_in;
   end

   assign done = done_ff;
   assign root = root_ff;
endmodule

// ----- sv/enacc_div.sv -----
// enacc_div: restoring divider, one quotient bit per cycle, Q16.16 saturating.
// Uses enacc_pkg.
`timescale 1ns / 1ps
module enacc_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [enacc_pkg::NUM_BITS-1:0]   num,
   input  logic [enacc_pkg::NUM_BITS-1:0]   den,
   output logic                             done,
   output logic [enacc_pkg::Q_BITS-1:0]     quot
);
   localparam int NB = enacc_pkg::NUM_BITS;
   localparam int DB = enacc_pkg::NUM_BITS + enacc_pkg::Q_SHIFT;
   localparam int QB = enacc_pkg::Q_BITS;

   logic [NB-1:0] rem_ff, rem_in, den_ff, den_in;
   logic [DB-1:0] dvd_ff, dvd_in, q_ff, q_in;
   logic [5:0]    cnt_ff, cnt_in;
   logic          busy_ff, busy_in, done_ff, done_in;
   logic [NB:0]   rem_sh;

   always_comb begin
      rem_sh  = {rem_ff, dvd_ff[DB-1]};
      rem_in  = rem_ff;
      den_in  = den_ff;
      dvd_in  = dvd_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         den_in  = den;
         dvd_in  = {num, {enacc_pkg::Q_SHIFT{1'b0}}};
         q_in    = '0;
         cnt_in  = 6'(DB - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[DB-2:0], 1'b0};
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = NB'(rem_sh - {1'b0, den_ff});
            q_in   = {q_ff[DB-2:0], 1'b1};
         end else begin
            rem_in = NB'(rem_sh);
            q_in   = {q_ff[DB-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      dvd_ff <= dvd_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign quot = (|q_ff[DB-1:QB]) ? {QB{1'b1}} : q_ff[QB-1:0];
endmodule

// ----- sv/error_norm_accumulator.sv -----
// error_norm_accumulator: L1 / L2 / Linf error norms, absolute and relative.
// Uses enacc_pkg, enacc_isqrt, enacc_div.
// Flow: a cell is accepted in idle, then each component takes an error step and a
// reference step on one shared squarer (while under MAX_CELLS cells); a last cell adds
// two square roots (error, then reference), up to three divides and a step to load
// the result item. A new cell is accepted only in idle (req_stall is high otherwise).
// Reset: synchronous, clears accumulators, sets count_ff to 2.
`timescale 1ns / 1ps
module error_norm_accumulator #(
   parameter int MAX_CELLS   = enacc_pkg::MAX_CELLS_DEF,
   parameter int SAMPLE_BITS = enacc_pkg::SAMPLE_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  enacc_pkg::req_type  req_payload,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output enacc_pkg::rsp_type  rsp_payload,
   input  logic                csr_wr_en,
   input  logic [1:0]          csr_wr_data
);
   localparam int SH = 24 - SAMPLE_BITS;
   localparam int CB = enacc_pkg::CELL_BITS;
   localparam int NB = enacc_pkg::NUM_BITS;

   typedef enum logic [2:0] {
      S_IDLE, S_ACC, S_SQD, S_SQR, S_DV1, S_DV2, S_DV3, S_DONE
   } state_type;

   state_type           state_ff;
   enacc_pkg::req_type  item_ff;
   enacc_pkg::rsp_type  rsp_ff;
   logic                rsp_valid_ff;
   logic [1:0]          count_ff;
   logic [1:0]          phase_ff;
   logic                go_ff;
   logic [37:0]         dabs_ff;
   logic [36:0]         rabs_ff;
   logic [61:0]         dsq_ff;
   logic [60:0]         rsq_ff;
   logic [23:0]         dpk_ff, rpk_ff;
   logic [CB-1:0]       cells_ff;
   logic [30:0]         l2d_ff, l2r_ff;
   logic [31:0]         rel1_ff, rel2_ff, rel3_ff;
   logic [2:0]          zmask_ff;

   logic signed [23:0]  t_raw, r_raw, t_s, r_s;
   logic signed [24:0]  diff;
   logic [23:0]         dmag, rmag, mag;
   logic [47:0]         sq;
   logic                last_phase;
   logic                sq_start, sq_done, dv_start, dv_done;
   logic [enacc_pkg::SQ_BITS-1:0] sq_val;
   logic [30:0]         sq_root;
   logic [NB-1:0]       dv_num, dv_den;
   logic [31:0]         dv_q;
   logic                den_zero;

   always_comb begin
      t_raw = phase_ff[1] ? item_ff.test_y : item_ff.test_x;
      r_raw = phase_ff[1] ? item_ff.ref_y : item_ff.ref_x;
      t_s   = $signed(t_raw << SH) >>> SH;
      r_s   = $signed(r_raw << SH) >>> SH;
      diff  = 25'(t_s) - 25'(r_s);
      dmag  = diff[24] ? 24'(-diff) : 24'(diff);
      rmag  = r_s[23] ? 24'(-25'(r_s)) : 24'(r_s);
      mag   = phase_ff[0] ? rmag : dmag;
      sq    = mag * mag;
      last_phase = (phase_ff == 2'd3) ||
                   (phase_ff == 2'd1 && count_ff == enacc_pkg::ONE_COMPONENT);
   end

   assign sq_val   = (state_ff == S_SQD) ? dsq_ff : {1'b0, rsq_ff};
   assign sq_start = (state_ff == S_SQD || state_ff == S_SQR) && !go_ff;

   always_comb begin
      unique case (state_ff)
         S_DV1: begin
            dv_num = dabs_ff;
            dv_den = {1'b0, rabs_ff};
         end
         S_DV2: begin
            dv_num = NB'(l2d_ff);
            dv_den = NB'(l2r_ff);
         end
         default: begin
            dv_num = NB'(dpk_ff);
            dv_den = NB'(rpk_ff);
         end
      endcase
      den_zero = (dv_den == '0);
   end

   assign dv_start = (state_ff == S_DV1 || state_ff == S_DV2 || state_ff == S_DV3)
                     && !go_ff && !den_zero;

   enacc_isqrt u_isqrt (
      .clock (clock), .reset (reset), .start (sq_start), .value (sq_val),
      .done (sq_done), .root (sq_root)
   );

   enacc_div u_div (
      .clock (clock), .reset (reset), .start (dv_start), .num (dv_num),
      .den (dv_den), .done (dv_done), .quot (dv_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= enacc_pkg::COUNT_RESET;
         phase_ff     <= '0;
         go_ff        <= 1'b0;
         dabs_ff      <= '0;
         rabs_ff      <= '0;
         dsq_ff       <= '0;
         rsq_ff       <= '0;
         dpk_ff       <= '0;
         rpk_ff       <= '0;
         cells_ff     <= '0;
      end else begin
         if (csr_wr_en) begin
            count_ff <= csr_wr_data;
         end
         if (rsp_valid_ff && !rsp_stall && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         if (sq_start || dv_start) begin
            go_ff <= 1'b1;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  item_ff  <= req_payload;
                  phase_ff <= '0;
                  state_ff <= S_ACC;
               end
            end
            S_ACC: begin
               if (cells_ff < CB'(MAX_CELLS)) begin
                  if (phase_ff[0]) begin
                     rabs_ff <= rabs_ff + 37'(mag);
                     rsq_ff  <= rsq_ff + 61'(sq);
                     if (mag > rpk_ff) rpk_ff <= mag;
                  end else begin
                     dabs_ff <= dabs_ff + 38'(mag);
                     dsq_ff  <= dsq_ff + 62'(sq);
                     if (mag > dpk_ff) dpk_ff <= mag;
                  end
                  if (last_phase) cells_ff <= cells_ff + CB'(1);
               end
               phase_ff <= phase_ff + 2'd1;
               if (last_phase || !(cells_ff < CB'(MAX_CELLS))) begin
                  state_ff <= item_ff.last_cell ? S_SQD : S_IDLE;
               end
            end
            S_SQD: begin
               if (sq_done) begin
                  l2d_ff   <= sq_root;
                  go_ff    <= 1'b0;
                  state_ff <= S_SQR;
               end
            end
            S_SQR: begin
               if (sq_done) begin
                  l2r_ff   <= sq_root;
                  go_ff    <= 1'b0;
                  state_ff <= S_DV1;
               end
            end
            S_DV1: begin
               if (den_zero || dv_done) begin
                  rel1_ff     <= den_zero ? '1 : dv_q;
                  zmask_ff[0] <= den_zero;
                  go_ff       <= 1'b0;
                  state_ff    <= S_DV2;
               end
            end
            S_DV2: begin
               if (den_zero || dv_done) begin
                  rel2_ff     <= den_zero ? '1 : dv_q;
                  zmask_ff[1] <= den_zero;
                  go_ff       <= 1'b0;
                  state_ff    <= S_DV3;
               end
            end
            S_DV3: begin
               if (den_zero || dv_done) begin
                  rel3_ff     <= den_zero ? '1 : dv_q;
                  zmask_ff[2] <= den_zero;
                  go_ff       <= 1'b0;
                  state_ff    <= S_DONE;
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_ff.abs_l1        <= dabs_ff[36:0];
                  rsp_ff.abs_l2        <= l2d_ff;
                  rsp_ff.abs_linf      <= dpk_ff;
                  rsp_ff.ref_l1        <= rabs_ff;
                  rsp_ff.ref_l2        <= l2r_ff[29:0];
                  rsp_ff.ref_linf      <= rpk_ff;
                  rsp_ff.rel_l1        <= rel1_ff;
                  rsp_ff.rel_l2        <= rel2_ff;
                  rsp_ff.rel_linf      <= rel3_ff;
                  rsp_ff.zero_ref_mask <= zmask_ff;
                  rsp_ff.cell_total    <= 13'(cells_ff);
                  rsp_valid_ff         <= 1'b1;
                  dabs_ff  <= '0;
                  rabs_ff  <= '0;
                  dsq_ff   <= '0;
                  rsq_ff   <= '0;
                  dpk_ff   <= '0;
                  rpk_ff   <= '0;
                  cells_ff <= '0;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_stall   = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
endmodule

// ----- verif/tb.sv -----
// tb: self-checking testbench for error_norm_accumulator.
// Predicts L1/L2/Linf norms per dataset and compares every result item.
// Depends on enacc_pkg and error_norm_accumulator.
`timescale 1ns / 1ps
module tb;

   localparam int CELL_LIMIT = 4096;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   enacc_pkg::req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   enacc_pkg::rsp_type rsp_payload;
   logic    csr_wr_en = 1'b0;
   logic [1:0] csr_wr_data = '0;

   enacc_pkg::rsp_type expected_norms[$];
   int      failures = 0;
   bit      stall_free = 1'b0;
   int      stall_left = 0;

   logic [1:0]  comp_sel;
   logic [63:0] err_sum, base_sum, err_sq, base_sq, err_peak, base_peak;
   int          cell_count;

   error_norm_accumulator uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [63:0] root_floor(input logic [63:0] v);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic [31:0] q16_ratio(input logic [63:0] num, input logic [63:0] den);
      logic [127:0] q;
      if (den == 0) return 32'hFFFF_FFFF;
      q = ({64'd0, num} << 16) / den;
      return (q > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
   endfunction

   task automatic add_component(input logic signed [23:0] t, input logic signed [23:0] r);
      longint d, a;
      d = longint'(t) - longint'(r);
      if (d < 0) d = -d;
      a = (r < 0) ? -longint'(r) : longint'(r);
      err_sum += d;
      base_sum += a;
      err_sq += d * d;
      base_sq += a * a;
      if (d > err_peak) err_peak = d;
      if (a > base_peak) base_peak = a;
   endtask

   task automatic clear_norms();
      err_sum = 0; base_sum = 0; err_sq = 0; base_sq = 0;
      err_peak = 0; base_peak = 0; cell_count = 0;
   endtask

   task automatic predict_cell(input enacc_pkg::req_type c);
      logic [63:0] rd, rr;
      enacc_pkg::rsp_type e;
      if (cell_count < CELL_LIMIT) begin
         add_component(c.test_x, c.ref_x);
         if (comp_sel != enacc_pkg::ONE_COMPONENT) add_component(c.test_y, c.ref_y);
         cell_count++;
      end
      if (c.last_cell) begin
         rd = root_floor(err_sq);
         rr = root_floor(base_sq);
         e.abs_l1 = err_sum[36:0];
         e.abs_l2 = rd[30:0];
         e.abs_linf = err_peak[23:0];
         e.ref_l1 = base_sum[36:0];
         e.ref_l2 = rr[29:0];
         e.ref_linf = base_peak[23:0];
         e.rel_l1 = q16_ratio(err_sum, base_sum);
         e.rel_l2 = q16_ratio(rd, rr);
         e.rel_linf = q16_ratio(err_peak, base_peak);
         e.zero_ref_mask = {base_peak == 0, rr == 0, base_sum == 0};
         e.cell_total = cell_count[12:0];
         expected_norms.insert(expected_norms.size(), e);
         clear_norms();
      end
   endtask

   task automatic send_cell(input enacc_pkg::req_type c, input bit gaps);
      int w;
      w = gaps ? (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19)) : 0;
      if (w != 0) begin
         req_valid <= 1'b0;
         repeat (w) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= c;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_cell(c);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_norms.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic set_components(input logic [1:0] v);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      comp_sel = v;
   endtask

   function automatic enacc_pkg::req_type make_cell(input int a, input int b, input int c,
                                                    input int d, input bit l);
      enacc_pkg::req_type x;
      x.test_x = 24'(a); x.ref_x = 24'(b); x.test_y = 24'(c); x.ref_y = 24'(d);
      x.last_cell = l;
      return x;
   endfunction

   function automatic logic signed [23:0] rand_sample();
      case ($urandom_range(0, 5))
         0: return 24'sh800000;
         1: return 24'sh7FFFFF;
         2: return 24'($urandom_range(0, 15) - 8);
         default: return 24'($urandom());
      endcase
   endfunction

   // checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_norms.size() == 0) begin
            $display("%0t: unexpected item %h", $time, rsp_payload);
            failures++;
         end else begin
            if (rsp_payload !== expected_norms[0]) begin
               $display("%0t: mismatch expected %p actual %p", $time,
                        expected_norms[0], rsp_payload);
               failures++;
            end
            void'(expected_norms.pop_front());
         end
      end
   end

   // receiver stalls for a random hold-off after each taken item, unless stall_free is set
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall) stall_left = stall_free ? 0 : int'($urandom_range(0, 19));
      else if (stall_left != 0) stall_left = stall_left - 1;
      rsp_stall <= (stall_left != 0);
   end

   task automatic test_directed();
      send_cell(make_cell(0, 0, 0, 0, 1), 0);
      send_cell(make_cell(-8388608, 8388607, 8388607, -8388608, 0), 0);
      send_cell(make_cell(8388607, -8388608, -8388608, 8388607, 1), 0);
      send_cell(make_cell(5, 5, -3, -3, 1), 0);
      send_cell(make_cell(1000, 1, 0, 0, 0), 0);
      send_cell(make_cell(-7, 2, 3, -1, 1), 1);
      send_cell(make_cell(123, 0, 0, 0, 1), 0);
   endtask

   task automatic test_one_component();
      set_components(enacc_pkg::ONE_COMPONENT);
      send_cell(make_cell(-8388608, 8388607, 77, -99, 1), 0);
      send_cell(make_cell(4, 0, 8388607, -8388608, 1), 0);
      send_cell(make_cell(10, 3, 1, 1, 0), 1);
      send_cell(make_cell(-10, -3, 1, 1, 1), 1);
   endtask

   task automatic test_unused_codes();
      set_components(2'd0);
      send_cell(make_cell(1, 2, 3, 4, 1), 0);
      set_components(2'd3);
      send_cell(make_cell(-1, -2, -3, -4, 1), 0);
      set_components(enacc_pkg::COUNT_RESET);
   endtask

   task automatic test_random(input int total);
      int n;
      n = 0;
      while (n < total) begin
         int len;
         len = $urandom_range(1, 12);
         for (int i = 0; i < len && n < total; i++, n++)
            send_cell(make_cell(rand_sample(), rand_sample(), rand_sample(), rand_sample(),
                                i == len - 1), 1);
         if (n > total / 2 && n < total / 2 + 13) begin
            drain();
            stall_free = ~stall_free;
         end
      end
      stall_free = 1'b0;
   endtask

   initial begin
      comp_sel = enacc_pkg::COUNT_RESET;
      clear_norms();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_one_component();
      test_unused_codes();
      test_random(300);
      set_components(enacc_pkg::ONE_COMPONENT);
      test_random(200);
      set_components(2'd0);
      test_random(150);
      drain();
      if (failures == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

   initial begin
      #6000000;
      $display("Verification failed");
      $finish;
   end
endmodule

// ----- files.f -----
sv/enacc_pkg.sv
sv/enacc_isqrt.sv
sv/enacc_div.sv
sv/error_norm_accumulator.sv
verif/tb.sv
